FILE: rtl/rbcs_pkg.sv
// Shared types and constants for the rank-by-counting-sort unit.
// Used by rbcs_ctrl, rbcs_dpath and rank_by_counting_sort_unit; no dependencies.
`timescale 1ns / 1ps

package rbcs_pkg;

  parameter int unsigned MAX_ITEMS_DEF = 16;

  parameter int unsigned HANDLE_W = 32;
  parameter int unsigned SCORE_W  = 32;
  parameter int unsigned POS_W    = 4;
  parameter int unsigned LEVEL_W  = 10;
  parameter int unsigned EXP_W    = 20;
  // level*100000 + experience stays below 2^27
  parameter int unsigned PROD_W   = 27;

  parameter logic [16:0] LEVEL_SCALE = 17'd100000;
  parameter logic [7:0]  LETTER_A    = 8'h41;
  parameter logic [7:0]  LETTER_Z    = 8'h5A;

  typedef struct packed {
    logic                       present;
    logic                       handle_ok;
    logic [7:0]                 type_letter;
    logic                       disabled;
    logic                       is_unit;
    logic [HANDLE_W-1:0]        handle;
    logic [LEVEL_W-1:0]         level;
    logic [EXP_W-1:0]           experience;
    logic signed [SCORE_W-1:0]  term_a;
    logic signed [SCORE_W-1:0]  term_b;
    logic signed [SCORE_W-1:0]  term_c;
    logic                       last;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]    position;
    logic                filled;
    logic [HANDLE_W-1:0] slot_handle;
    logic                final_res;
  } out_item_t;

  typedef enum logic {
    RD_CTRL,
    RD_SLOT
  } rd_sel_e;

  typedef struct packed {
    logic    item_load;
    logic    row_we;
    rd_sel_e rd_sel;
    logic    pivot_load;
    logic    beats_clr;
    logic    cmp_en;
    logic    slot_we;
    logic    out_load;
    logic    out_single;
    logic    out_final;
  } cmd_t;

  typedef struct packed {
    logic item_last;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/rank_by_counting_sort_unit.sv
// Top level of the rank-by-counting-sort unit: controller plus datapath.
// Depends on rbcs_pkg, rbcs_ctrl and rbcs_dpath.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+----------------------------
//   in      | input     | in_valid_i / in_stall_o   | in_data_i  (in_item_t)
//   out     | output    | out_valid_o / out_stall_i | out_data_o (out_item_t)
//
// Each candidate is loaded, scored in a multiply stage, then written to the row store.
// On the last candidate of a set of n >= 2 rows, the ranking pass reads the row
// store through one port, comparing one pivot against one row a cycle; then
// each slot is emitted in turn, held while the output stalls.
// A set of one is emitted unranked from the item register. Reset: idle, empty set.
// Candidates are taken only while idle; a stalled result holds in the output register.
`timescale 1ns / 1ps

module rank_by_counting_sort_unit #(
  parameter int unsigned MaxItems = rbcs_pkg::MAX_ITEMS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rbcs_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rbcs_pkg::out_item_t out_data_o
);

  import rbcs_pkg::*;

  localparam int unsigned AddrW = $clog2(MaxItems);
  localparam int unsigned CntW  = $clog2(MaxItems + 1);

  cmd_t             cmd;
  sts_t             sts;
  logic [AddrW-1:0] row_addr;
  logic [AddrW-1:0] slot_addr;
  logic [CntW-1:0]  count;

  rbcs_ctrl #(
    .MaxItems (MaxItems),
    .AddrW    (AddrW),
    .CntW     (CntW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .row_addr_o  (row_addr),
    .slot_addr_o (slot_addr),
    .count_o     (count)
  );

  rbcs_dpath #(
    .MaxItems (MaxItems),
    .AddrW    (AddrW),
    .CntW     (CntW)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .row_addr_i  (row_addr),
    .slot_addr_i (slot_addr),
    .count_i     (count),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: rtl/rbcs_dpath.sv
// Datapath: item register, score arithmetic, row store, pairwise compare,
// slot table and output register. Depends on rbcs_pkg; driven by rbcs_ctrl.
`timescale 1ns / 1ps

module rbcs_dpath #(
  parameter int unsigned MaxItems = rbcs_pkg::MAX_ITEMS_DEF,
  parameter int unsigned AddrW    = $clog2(MaxItems),
  parameter int unsigned CntW     = $clog2(MaxItems + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rbcs_pkg::in_item_t  in_data_i,
  input  rbcs_pkg::cmd_t      cmd_i,
  input  logic [AddrW-1:0]    row_addr_i,
  input  logic [AddrW-1:0]    slot_addr_i,
  input  logic [CntW-1:0]     count_i,
  output rbcs_pkg::sts_t      sts_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rbcs_pkg::out_item_t out_data_o
);

  import rbcs_pkg::*;

  typedef struct packed {
    logic [SCORE_W-1:0]  score;
    logic [HANDLE_W-1:0] handle;
    logic                valid;
    logic                keep;
  } row_t;

  in_item_t           item_q;
  logic [PROD_W-1:0]  prod_q;
  logic [SCORE_W-1:0] abc_q;
  logic               item_valid;
  row_t               wr_row;

  row_t               row_mem [MaxItems];
  row_t               row_q;
  logic [AddrW-1:0]   rd_addr;
  logic [AddrW-1:0]   rd_idx_q;

  logic [AddrW-1:0]   slot_mem [MaxItems];
  logic [AddrW-1:0]   slot_q;
  logic [AddrW-1:0]   slot_wr_addr;

  row_t               pivot_q;
  logic [AddrW-1:0]   pivot_idx_q;
  logic [AddrW-1:0]   beats_q;
  logic               pivot_wins;

  logic               out_valid_q;
  out_item_t          out_q;
  logic               out_free;

  // ---- load and score ----
  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      item_q <= in_data_i;
    end
    prod_q <= PROD_W'(item_q.level) * PROD_W'(LEVEL_SCALE) + PROD_W'(item_q.experience);
    abc_q  <= item_q.term_a + item_q.term_b + item_q.term_c;
  end

  assign item_valid = item_q.present && item_q.handle_ok && !item_q.disabled &&
                      (item_q.type_letter >= LETTER_A) && (item_q.type_letter <= LETTER_Z);

  always_comb begin
    wr_row.valid  = item_valid;
    wr_row.keep   = item_valid && item_q.is_unit;
    wr_row.handle = item_q.present ? item_q.handle : '0;
    // x10 as two shifted copies, wraps in 32 bits
    wr_row.score  = item_valid ?
                    SCORE_W'({prod_q, 3'b000}) + SCORE_W'({prod_q, 1'b0}) + abc_q : '0;
  end

  // ---- row store ----
  assign rd_addr = (cmd_i.rd_sel == RD_SLOT) ? slot_q : row_addr_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.row_we) begin
      row_mem[row_addr_i] <= wr_row;
    end
    row_q    <= row_mem[rd_addr];
    rd_idx_q <= rd_addr;
  end

  // ---- compare pivot row against the row just read ----
  always_comb begin
    if (pivot_q.score != row_q.score) begin
      pivot_wins = $signed(pivot_q.score) > $signed(row_q.score);
    end else if (pivot_q.valid != row_q.valid) begin
      pivot_wins = pivot_q.valid;
    end else if (pivot_q.valid && (pivot_q.handle != row_q.handle)) begin
      pivot_wins = pivot_q.handle < row_q.handle;
    end else begin
      pivot_wins = pivot_idx_q < rd_idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pivot_load) begin
      pivot_q     <= row_q;
      pivot_idx_q <= rd_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beats_q <= '0;
    end else if (cmd_i.beats_clr) begin
      beats_q <= '0;
    end else if (cmd_i.cmp_en && (rd_idx_q != pivot_idx_q) && pivot_wins) begin
      beats_q <= beats_q + AddrW'(1);
    end
  end

  // ---- slot table: slot = count - beats - 1 ----
  assign slot_wr_addr = AddrW'(count_i - CntW'(1) - CntW'(beats_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.slot_we) begin
      slot_mem[slot_wr_addr] <= pivot_idx_q;
    end
    slot_q <= slot_mem[slot_addr_i];
  end

  // ---- output register ----
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (cmd_i.out_single) begin
        // set of one: not ranked, filled follows present
        out_q.position    <= '0;
        out_q.filled      <= item_q.present;
        out_q.slot_handle <= item_q.present ? item_q.handle : '0;
        out_q.final_res   <= 1'b1;
      end else begin
        out_q.position    <= POS_W'(slot_addr_i);
        out_q.filled      <= row_q.keep;
        out_q.slot_handle <= row_q.keep ? row_q.handle : '0;
        out_q.final_res   <= cmd_i.out_final;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;
  assign sts_o.item_last = item_q.last;
  assign sts_o.out_free  = out_free;

  a_out_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> out_free)
    else $error("output register overwritten while held");

  a_slot_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.slot_we |-> (CntW'(beats_q) < count_i))
    else $error("beat count reached set size");

  a_load_not_ranking: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.row_we |-> !cmd_i.cmp_en && !cmd_i.slot_we && !cmd_i.pivot_load)
    else $error("row store written during ranking");

endmodule

FILE: rtl/rbcs_ctrl.sv
// Controller: sequences loading, the all-pairs ranking pass and slot emission.
// Depends on rbcs_pkg; commands rbcs_dpath.
`timescale 1ns / 1ps

module rbcs_ctrl #(
  parameter int unsigned MaxItems = rbcs_pkg::MAX_ITEMS_DEF,
  parameter int unsigned AddrW    = $clog2(MaxItems),
  parameter int unsigned CntW     = $clog2(MaxItems + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  rbcs_pkg::sts_t   sts_i,
  output rbcs_pkg::cmd_t   cmd_o,
  output logic [AddrW-1:0] row_addr_o,
  output logic [AddrW-1:0] slot_addr_o,
  output logic [CntW-1:0]  count_o
);

  import rbcs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_WR,
    S_PIV,
    S_PIV2,
    S_CMP,
    S_SLOT,
    S_E1,
    S_E2,
    S_E3,
    S_ONE
  } state_e;

  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxItems);

  state_e           state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [AddrW-1:0] i_q, i_d;
  logic [CntW-1:0]  k_q, k_d;
  logic [CntW-1:0]  cnt_inc;
  logic             room;

  assign room    = cnt_q < MaxCnt;
  assign cnt_inc = room ? cnt_q + CntW'(1) : cnt_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    i_d     = i_q;
    k_d     = k_q;
    cmd_o   = '0;
    cmd_o.rd_sel = RD_CTRL;
    row_addr_o   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.item_load = 1'b1;
          state_d = S_MUL;
        end
      end
      S_MUL: state_d = S_WR;
      S_WR: begin
        row_addr_o   = cnt_q[AddrW-1:0];
        cmd_o.row_we = room;  // overflow candidates are dropped
        cnt_d        = cnt_inc;
        state_d      = S_IDLE;
        if (sts_i.item_last) begin
          i_d = '0;
          if (cnt_inc == CntW'(1)) begin
            cnt_d   = '0;
            state_d = S_ONE;
          end else if (cnt_inc != '0) begin
            state_d = S_PIV;
          end
        end
      end
      S_PIV: begin
        row_addr_o = i_q;
        state_d    = S_PIV2;
      end
      S_PIV2: begin
        cmd_o.pivot_load = 1'b1;
        cmd_o.beats_clr  = 1'b1;
        row_addr_o       = '0;
        k_d              = CntW'(1);
        state_d          = S_CMP;
      end
      S_CMP: begin
        // row k-1 is in the read register this cycle
        cmd_o.cmp_en = 1'b1;
        row_addr_o   = k_q[AddrW-1:0];
        if (k_q == cnt_q) begin
          state_d = S_SLOT;
        end else begin
          k_d = k_q + CntW'(1);
        end
      end
      S_SLOT: begin
        cmd_o.slot_we = 1'b1;
        if (CntW'(i_q) == cnt_q - CntW'(1)) begin
          k_d     = '0;
          state_d = S_E1;
        end else begin
          i_d     = i_q + AddrW'(1);
          state_d = S_PIV;
        end
      end
      S_E1: state_d = S_E2;
      S_E2: begin
        cmd_o.rd_sel = RD_SLOT;
        state_d      = S_E3;
      end
      S_E3: begin
        // keep reading the slot's row so it holds while the output waits
        cmd_o.rd_sel = RD_SLOT;
        if (sts_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_final = (k_q == cnt_q - CntW'(1));
          if (k_q == cnt_q - CntW'(1)) begin
            cnt_d   = '0;
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + CntW'(1);
            state_d = S_E1;
          end
        end
      end
      S_ONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_single = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      i_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      i_q     <= i_d;
      k_q     <= k_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign slot_addr_o = k_q[AddrW-1:0];
  assign count_o     = cnt_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MaxCnt)
    else $error("loaded count above capacity");

  a_cmp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> (k_q != '0) && (k_q <= cnt_q) && (cnt_q > CntW'(1)))
    else $error("compare index out of range");

  a_pivot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SLOT) |-> (CntW'(i_q) < cnt_q))
    else $error("pivot row beyond loaded set");

  a_emit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_load && cmd_o.out_final) |=> (state_q == S_IDLE) && (cnt_q == '0))
    else $error("emission ended without returning to idle");

endmodule
